[rtl/v4a_pkg.sv]
// Shared types, constants and helpers for the four-lane fixed-point vector unit.
// No dependencies; every other file imports this package.
package v4a_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LANES     = 4;
  localparam int DW        = 32;
  localparam int ROOT_W    = DW + 1;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int NUM_W     = DW + FRAC_BITS;
  localparam int DEN_W     = ROOT_W;
  localparam int REM_W     = DEN_W + 1;
  localparam int WIDE_W    = 70;
  localparam int IN_W      = 296;
  localparam int OUT_W     = 168;

  localparam logic [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [3:0] {
    CMD_ADD, CMD_SUB, CMD_SCALE, CMD_DIVIDE, CMD_DOT, CMD_LENSQ, CMD_LEN,
    CMD_MAX, CMD_NORM, CMD_LERP, CMD_REFLECT, CMD_EQ, CMD_NE
  } cmd_t;

  typedef logic [DW-1:0] word_t;
  typedef logic [LANES-1:0][DW-1:0] vec_t;

  typedef struct packed {
    cmd_t  cmd;
    vec_t  r;
    word_t sc;
    logic  cmp;
    logic  sat;
    logic  derr;
  } pre_t;

  typedef struct packed {
    vec_t  a;
    word_t f;
  } dop_t;

  typedef struct packed {
    word_t v;
    logic  s;
  } clip_t;

  // Clips a wide signed value to the 32-bit range and reports whether it clipped.
  function automatic clip_t clip32(input logic signed [WIDE_W-1:0] v);
    clip_t c;
    logic [WIDE_W-DW:0] top;
    top = v[WIDE_W-1:DW-1];
    if ((&top) || !(|top)) begin
      c.v = v[DW-1:0];
      c.s = 1'b0;
    end else begin
      c.v = v[WIDE_W-1] ? WORD_MIN : WORD_MAX;
      c.s = 1'b1;
    end
    return c;
  endfunction

endpackage

[rtl/v4a_front.sv]
// Front pipeline: lane multiplies, product sum, per-lane results and the reflect pass.
// Depends on v4a_pkg.
module v4a_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  v4a_pkg::cmd_t             in_cmd,
  input  v4a_pkg::vec_t             in_a,
  input  v4a_pkg::vec_t             in_b,
  input  v4a_pkg::word_t            in_f,
  output logic                      out_valid,
  output v4a_pkg::pre_t             out_pre,
  output logic [v4a_pkg::RAD_W-1:0] out_rad,
  output v4a_pkg::dop_t             out_op
);
  import v4a_pkg::*;

  localparam int PW = 2 * (DW + 1);
  localparam int SW = PW + 2;
  localparam int QW = 2 * DW;

  logic v1, v2, v3, v4, v5;

  logic signed [DW:0]   xs [LANES];
  logic signed [DW:0]   ys [LANES];
  logic signed [PW-1:0] p_next [LANES];
  cmd_t                 cmd1;
  vec_t                 a1, b1;
  word_t                f1;
  logic signed [PW-1:0] p1 [LANES];

  logic signed [SW-1:0] sum_next;
  cmd_t                 cmd2;
  vec_t                 a2, b2;
  word_t                f2;
  logic signed [PW-1:0] p2 [LANES];
  logic signed [SW-1:0] sum2;

  pre_t                 pre3_next;
  word_t                d_next;
  logic signed [SW-1:0] dotv;
  clip_t                dc, c3;
  word_t                mx;
  pre_t                 pre3;
  word_t                d3, f3;
  vec_t                 a3, b3;
  logic [RAD_W-1:0]     rad3;

  logic signed [QW-1:0] q_next [LANES];
  pre_t                 pre4;
  vec_t                 a4;
  word_t                f4;
  logic [RAD_W-1:0]     rad4;
  logic signed [QW-1:0] q4 [LANES];

  pre_t                 pre5_next;
  clip_t                c5;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      xs[i] = '0;
      ys[i] = '0;
      case (in_cmd)
        CMD_SCALE: begin
          xs[i] = (DW+1)'($signed(in_a[i]));
          ys[i] = (DW+1)'($signed(in_f));
        end
        CMD_LERP: begin
          xs[i] = (DW+1)'($signed(in_b[i])) - (DW+1)'($signed(in_a[i]));
          ys[i] = (DW+1)'($signed(in_f));
        end
        CMD_DOT, CMD_REFLECT: begin
          xs[i] = (DW+1)'($signed(in_a[i]));
          ys[i] = (DW+1)'($signed(in_b[i]));
        end
        CMD_LENSQ, CMD_LEN, CMD_NORM: begin
          xs[i] = (DW+1)'($signed(in_a[i]));
          ys[i] = (DW+1)'($signed(in_a[i]));
        end
        default: begin
        end
      endcase
      p_next[i] = xs[i] * ys[i];
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_next = sum_next + SW'(p1[i]);
    end
  end

  always_comb begin
    pre3_next     = '0;
    pre3_next.cmd = cmd2;
    d_next        = '0;
    c3            = '0;
    dotv          = sum2 >>> FRAC_BITS;
    dc            = clip32(WIDE_W'(dotv));
    mx            = a2[0];
    for (int i = 1; i < LANES; i++) begin
      if ($signed(a2[i]) > $signed(mx)) begin
        mx = a2[i];
      end
    end
    case (cmd2)
      CMD_ADD, CMD_SUB, CMD_SCALE, CMD_LERP: begin
        for (int i = 0; i < LANES; i++) begin
          case (cmd2)
            CMD_ADD:   c3 = clip32(WIDE_W'($signed(a2[i])) + WIDE_W'($signed(b2[i])));
            CMD_SUB:   c3 = clip32(WIDE_W'($signed(a2[i])) - WIDE_W'($signed(b2[i])));
            CMD_SCALE: c3 = clip32(WIDE_W'(p2[i] >>> FRAC_BITS));
            default:   c3 = clip32(WIDE_W'($signed(a2[i])) + WIDE_W'(p2[i] >>> FRAC_BITS));
          endcase
          pre3_next.r[i] = c3.v;
          pre3_next.sat  = pre3_next.sat | c3.s;
        end
      end
      CMD_DOT, CMD_LENSQ: begin
        pre3_next.sc  = dc.v;
        pre3_next.sat = dc.s;
      end
      CMD_REFLECT: begin
        pre3_next.sat = dc.s;
        d_next        = dc.v;
      end
      CMD_MAX: pre3_next.sc  = mx;
      CMD_EQ:  pre3_next.cmp = (a2 == b2);
      CMD_NE:  pre3_next.cmp = (a2 != b2);
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      q_next[i] = $signed(b3[i]) * $signed(d3);
    end
  end

  always_comb begin
    pre5_next = pre4;
    c5        = '0;
    if (pre4.cmd == CMD_REFLECT) begin
      for (int i = 0; i < LANES; i++) begin
        c5 = clip32(WIDE_W'($signed(a4[i])) - WIDE_W'(q4[i] >>> (FRAC_BITS - 1)));
        pre5_next.r[i] = c5.v;
        pre5_next.sat  = pre5_next.sat | c5.s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= in_cmd;
      a1   <= in_a;
      b1   <= in_b;
      f1   <= in_f;
      p1   <= p_next;
      cmd2 <= cmd1;
      a2   <= a1;
      b2   <= b1;
      f2   <= f1;
      p2   <= p1;
      sum2 <= sum_next;
      pre3 <= pre3_next;
      d3   <= d_next;
      a3   <= a2;
      b3   <= b2;
      f3   <= f2;
      rad3 <= sum2[RAD_W-1:0];
      pre4 <= pre3;
      a4   <= a3;
      f4   <= f3;
      rad4 <= rad3;
      q4   <= q_next;
      out_pre  <= pre5_next;
      out_rad  <= rad4;
      out_op.a <= a4;
      out_op.f <= f4;
    end
  end

  assign out_valid = v5;

endmodule

[rtl/v4a_sqrt.sv]
// Pipelined integer square root, one result bit per stage, carrying the item along.
// Depends on v4a_pkg.
module v4a_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [v4a_pkg::RAD_W-1:0]  in_rad,
  input  v4a_pkg::dop_t              in_op,
  input  v4a_pkg::pre_t              in_pre,
  output logic                       out_valid,
  output logic [v4a_pkg::ROOT_W-1:0] out_root,
  output v4a_pkg::dop_t              out_op,
  output v4a_pkg::pre_t              out_pre
);
  import v4a_pkg::*;

  localparam int NS = ROOT_W;

  logic [RAD_W-1:0] vq [NS];
  logic [RAD_W-1:0] rq [NS];
  dop_t             oq [NS];
  pre_t             pq [NS];
  logic [NS-1:0]    vld;

  function automatic logic [2*RAD_W-1:0] sqrt_step(input logic [RAD_W-1:0] v,
                                                   input logic [RAD_W-1:0] r,
                                                   input int k);
    logic [RAD_W-1:0] bitv;
    logic [RAD_W-1:0] t;
    bitv = RAD_W'(1) << (2 * (NS - 1 - k));
    t    = r + bitv;
    if (v >= t) begin
      return {v - t, (r >> 1) + bitv};
    end
    return {v, r >> 1};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {vq[0], rq[0]} <= sqrt_step(in_rad, '0, 0);
      oq[0] <= in_op;
      pq[0] <= in_pre;
      for (int k = 1; k < NS; k++) begin
        {vq[k], rq[k]} <= sqrt_step(vq[k-1], rq[k-1], k);
        oq[k] <= oq[k-1];
        pq[k] <= pq[k-1];
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_root  = rq[NS-1][ROOT_W-1:0];
  assign out_op    = oq[NS-1];
  assign out_pre   = pq[NS-1];

endmodule

[rtl/v4a_div.sv]
// Four-lane pipelined restoring divider of a*2^F by a shared divisor, one bit per stage.
// Depends on v4a_pkg.
module v4a_div (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           en,
  input  logic                                           in_valid,
  input  v4a_pkg::vec_t                                  in_a,
  input  logic signed [v4a_pkg::DEN_W:0]                 in_den,
  input  v4a_pkg::pre_t                                  in_pre,
  output logic                                           out_valid,
  output logic [v4a_pkg::LANES-1:0][v4a_pkg::NUM_W-1:0]  out_mag,
  output logic [v4a_pkg::LANES-1:0]                      out_neg,
  output v4a_pkg::pre_t                                  out_pre
);
  import v4a_pkg::*;

  localparam int NS = NUM_W;

  logic [LANES-1:0][NUM_W-1:0] nq [NS+1];
  logic [LANES-1:0][REM_W-1:0] rq [NS+1];
  logic [DEN_W-1:0]            dq [NS+1];
  logic [LANES-1:0]            gq [NS+1];
  pre_t                        pq [NS+1];
  logic [NS:0]                 vld;

  logic [LANES-1:0][NUM_W-1:0] n0;
  logic [LANES-1:0]            g0;
  logic [DEN_W:0]              dabs;
  word_t                       am;

  function automatic logic [REM_W+NUM_W-1:0] div_step(input logic [REM_W-1:0] rem,
                                                      input logic [NUM_W-1:0] n,
                                                      input logic [DEN_W-1:0] d);
    logic [REM_W-1:0] t;
    t = {rem[REM_W-2:0], n[NUM_W-1]};
    if (t >= REM_W'(d)) begin
      return {t - REM_W'(d), n[NUM_W-2:0], 1'b1};
    end
    return {t, n[NUM_W-2:0], 1'b0};
  endfunction

  always_comb begin
    am   = '0;
    dabs = in_den[DEN_W] ? -in_den : in_den;
    for (int i = 0; i < LANES; i++) begin
      am    = in_a[i][DW-1] ? -in_a[i] : in_a[i];
      n0[i] = {am, {FRAC_BITS{1'b0}}};
      g0[i] = in_a[i][DW-1] ^ in_den[DEN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq[0] <= n0;
      rq[0] <= '0;
      dq[0] <= dabs[DEN_W-1:0];
      gq[0] <= g0;
      pq[0] <= in_pre;
      for (int k = 1; k <= NS; k++) begin
        for (int i = 0; i < LANES; i++) begin
          {rq[k][i], nq[k][i]} <= div_step(rq[k-1][i], nq[k-1][i], dq[k-1]);
        end
        dq[k] <= dq[k-1];
        gq[k] <= gq[k-1];
        pq[k] <= pq[k-1];
      end
    end
  end

  assign out_valid = vld[NS];
  assign out_mag   = nq[NS];
  assign out_neg   = gq[NS];
  assign out_pre   = pq[NS];

endmodule

[rtl/vec4_alu.sv]
// Four-lane signed Q16.16 vector unit. Stages from input beat to output beat:
// 5 front stages, 33 root stages, 1 + 48 divide stages, 1 output.
// Throughput is one beat per cycle; the whole pipeline holds while the output beat waits.
// Reset (rst, synchronous) clears all valid bits; no clearing pass is needed.
// Depends on v4a_pkg, v4a_front, v4a_sqrt and v4a_div.
module vec4_alu (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, factor, zero pad
  input  logic [v4a_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // r_x, r_y, r_z, r_w, scalar_out, compare_true, saturated, div_error, zero pad
  output logic [v4a_pkg::OUT_W-1:0]  m_tdata
);
  import v4a_pkg::*;

  logic                         en;
  logic                         fr_valid;
  pre_t                         fr_pre;
  logic [RAD_W-1:0]             fr_rad;
  dop_t                         fr_op;
  logic                         sq_valid;
  logic [ROOT_W-1:0]            sq_root;
  dop_t                         sq_op;
  pre_t                         sq_pre;
  pre_t                         dv_in_pre;
  logic signed [DEN_W:0]        den;
  logic                         dv_valid;
  logic [LANES-1:0][NUM_W-1:0]  dv_mag;
  logic [LANES-1:0]             dv_neg;
  pre_t                         dv_pre;
  pre_t                         o_next;
  word_t                        lo;
  word_t                        sv;
  logic                         big;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  v4a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_cmd    (cmd_t'(s_tdata[3:0])),
    .in_a      (s_tdata[4*DW+3:4]),
    .in_b      (s_tdata[8*DW+3:4*DW+4]),
    .in_f      (s_tdata[9*DW+3:8*DW+4]),
    .out_valid (fr_valid),
    .out_pre   (fr_pre),
    .out_rad   (fr_rad),
    .out_op    (fr_op)
  );

  v4a_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_rad    (fr_rad),
    .in_op     (fr_op),
    .in_pre    (fr_pre),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_op    (sq_op),
    .out_pre   (sq_pre)
  );

  always_comb begin
    dv_in_pre = sq_pre;
    den       = (DEN_W+1)'($signed(sq_op.f));
    case (sq_pre.cmd)
      CMD_LEN: begin
        dv_in_pre.sc  = (sq_root[ROOT_W-1] || sq_root[DW-1]) ? WORD_MAX : sq_root[DW-1:0];
        dv_in_pre.sat = sq_root[ROOT_W-1] || sq_root[DW-1];
      end
      CMD_DIVIDE: dv_in_pre.derr = (sq_op.f == '0);
      CMD_NORM: begin
        den            = (DEN_W+1)'(sq_root);
        dv_in_pre.derr = (sq_root == '0);
      end
      default: begin
      end
    endcase
  end

  v4a_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_a      (sq_op.a),
    .in_den    (den),
    .in_pre    (dv_in_pre),
    .out_valid (dv_valid),
    .out_mag   (dv_mag),
    .out_neg   (dv_neg),
    .out_pre   (dv_pre)
  );

  always_comb begin
    o_next = dv_pre;
    lo     = '0;
    sv     = '0;
    big    = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      lo  = dv_mag[i][DW-1:0];
      sv  = dv_neg[i] ? -lo : lo;
      big = |dv_mag[i][NUM_W-1:DW-1];
      if (dv_pre.cmd == CMD_DIVIDE && !dv_pre.derr) begin
        if (!dv_neg[i] && big) begin
          o_next.r[i] = WORD_MAX;
          o_next.sat  = 1'b1;
        end else if (dv_neg[i] && big && dv_mag[i] != (NUM_W'(1) << (DW - 1))) begin
          o_next.r[i] = WORD_MIN;
          o_next.sat  = 1'b1;
        end else begin
          o_next.r[i] = sv;
        end
      end else if (dv_pre.cmd == CMD_NORM && !dv_pre.derr) begin
        o_next.r[i] = sv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {{(OUT_W-5*DW-3){1'b0}}, o_next.derr, o_next.sat, o_next.cmp,
                  o_next.sc, o_next.r};
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for vec4_alu: directed and random operations drive the input stream.
// A predictor computes each result exactly, and the results are checked beat by beat.
// Depends on v4a_pkg and the vec4_alu RTL.
module tb;
  import v4a_pkg::*;

  typedef struct {
    logic [3:0]         cmd;
    logic signed [31:0] a [4];
    logic signed [31:0] b [4];
    logic signed [31:0] f;
  } op_t;

  typedef struct {
    logic [31:0] r [4];
    logic [31:0] sc;
    logic        cmp;
    logic        sat;
    logic        derr;
  } res_t;

  localparam int N_RANDOM = 1150;
  localparam int SETTLE   = 200;
  localparam int LIMIT    = 600000;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_W-1:0]  s_tdata;
  logic [OUT_W-1:0] m_tdata;

  op_t  op_queue [$];
  res_t result_queue [$];
  op_t  cur_op;
  bit   taken;
  int   n_sent, n_total, errors, cycles;

  vec4_alu DUT (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] sat32(input logic signed [127:0] v, inout bit s);
    if (v > 128'sd2147483647) begin
      s = 1;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      s = 1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] root_floor(input logic signed [127:0] s);
    logic signed [127:0] r, t;
    r = 0;
    for (int i = 33; i >= 0; i--) begin
      t = r | (128'sd1 <<< i);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic res_t vec_predict(input op_t op);
    res_t res;
    bit s;
    logic signed [127:0] a [4], b [4], f, acc, ln, d;
    s = 0;
    f = op.f;
    acc = 0;
    ln = 0;
    res.sc = 0;
    res.cmp = 0;
    res.derr = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = op.a[i];
      b[i] = op.b[i];
      res.r[i] = 0;
    end
    case (op.cmd)
      CMD_ADD:    for (int i = 0; i < 4; i++) res.r[i] = sat32(a[i] + b[i], s);
      CMD_SUB:    for (int i = 0; i < 4; i++) res.r[i] = sat32(a[i] - b[i], s);
      CMD_SCALE:  for (int i = 0; i < 4; i++) res.r[i] = sat32((a[i] * f) >>> FRAC_BITS, s);
      CMD_DIVIDE: begin
        if (f == 0) res.derr = 1;
        else for (int i = 0; i < 4; i++) res.r[i] = sat32((a[i] <<< FRAC_BITS) / f, s);
      end
      CMD_DOT: begin
        for (int i = 0; i < 4; i++) acc += a[i] * b[i];
        res.sc = sat32(acc >>> FRAC_BITS, s);
      end
      CMD_LENSQ: begin
        for (int i = 0; i < 4; i++) acc += a[i] * a[i];
        res.sc = sat32(acc >>> FRAC_BITS, s);
      end
      CMD_LEN: begin
        for (int i = 0; i < 4; i++) acc += a[i] * a[i];
        res.sc = sat32(root_floor(acc), s);
      end
      CMD_MAX: begin
        d = a[0];
        for (int i = 1; i < 4; i++) if (a[i] > d) d = a[i];
        res.sc = d[31:0];
      end
      CMD_NORM: begin
        for (int i = 0; i < 4; i++) acc += a[i] * a[i];
        ln = root_floor(acc);
        if (ln == 0) res.derr = 1;
        else for (int i = 0; i < 4; i++) res.r[i] = sat32((a[i] <<< FRAC_BITS) / ln, s);
      end
      CMD_LERP:
        for (int i = 0; i < 4; i++)
          res.r[i] = sat32(a[i] + (((b[i] - a[i]) * f) >>> FRAC_BITS), s);
      CMD_REFLECT: begin
        for (int i = 0; i < 4; i++) acc += a[i] * b[i];
        d = $signed(sat32(acc >>> FRAC_BITS, s));
        for (int i = 0; i < 4; i++)
          res.r[i] = sat32(a[i] - ((b[i] * d) >>> (FRAC_BITS - 1)), s);
      end
      CMD_EQ:     res.cmp = (op.a == op.b);
      CMD_NE:     res.cmp = (op.a != op.b);
      default: ;
    endcase
    res.sat = s;
    return res;
  endfunction

  function automatic logic [IN_W-1:0] pack_op(input op_t op);
    logic [IN_W-1:0] v;
    v = '0;
    v[3:0] = op.cmd;
    for (int i = 0; i < 4; i++) begin
      v[4 + 32*i +: 32] = op.a[i];
      v[132 + 32*i +: 32] = op.b[i];
    end
    v[260 +: 32] = op.f;
    return v;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(1) ? 32'h0001_0000 : 32'h0;
      3: return $urandom_range(2000) - 1000;
      4: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(input logic [3:0] cmd, input logic [31:0] a0, a1, a2, a3,
                        input logic [31:0] b0, b1, b2, b3, input logic [31:0] f);
    op_t op;
    op.cmd = cmd;
    op.a[0] = a0; op.a[1] = a1; op.a[2] = a2; op.a[3] = a3;
    op.b[0] = b0; op.b[1] = b1; op.b[2] = b2; op.b[3] = b3;
    op.f = f;
    op_queue.push_back(op);
  endtask

  task automatic check_word(input string name, input logic [31:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Input and output side: the monitor notes each accepted beat, predicts its result and checks each output beat.
  always @(posedge clk) begin
    cycles++;
    if (!rst && s_tvalid && s_tready) begin
      result_queue.push_back(vec_predict(cur_op));
      taken = 1;
      n_sent++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (result_queue.size() == 0) begin
        $error("unexpected output beat");
        errors++;
      end else begin
        res_t e;
        e = result_queue.pop_front();
        check_word("r_x", e.r[0], m_tdata[31:0]);
        check_word("r_y", e.r[1], m_tdata[63:32]);
        check_word("r_z", e.r[2], m_tdata[95:64]);
        check_word("r_w", e.r[3], m_tdata[127:96]);
        check_word("scalar_out", e.sc, m_tdata[159:128]);
        check_word("compare_true", e.cmp, m_tdata[160]);
        check_word("saturated", e.sat, m_tdata[161]);
        check_word("div_error", e.derr, m_tdata[162]);
      end
    end
  end

  always @(negedge clk) begin
    int tx_idle, rx_idle;
    if (n_sent < n_total / 3) begin
      tx_idle = 12; rx_idle = 68;
    end else if (n_sent < 2 * n_total / 3) begin
      tx_idle = 68; rx_idle = 12;
    end else begin
      tx_idle = 0; rx_idle = 0;
    end
    m_tready <= !rst && ($urandom_range(99) >= rx_idle);
    if (!rst && (!s_tvalid || taken)) begin
      taken = 0;
      if (op_queue.size() != 0 && $urandom_range(99) >= tx_idle) begin
        cur_op = op_queue.pop_front();
        s_tdata <= pack_op(cur_op);
        s_tvalid <= 1;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    op_t op;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    m_tready = 0;
    taken = 0;
    n_sent = 0;
    errors = 0;
    cycles = 0;
    for (int c = 0; c < 16; c++)
      add_op(4'(c), 32'h7fffffff, 32'h80000000, 32'h0001_8000, 32'hffff_0000,
             32'h7fffffff, 32'h80000000, 32'hfffe_8000, 32'h0000_0001, 32'h8000_0000);
    add_op(CMD_DIVIDE, 32'h0001_0000, 32'h2, 32'h3, 32'h4, 0, 0, 0, 0, 0);
    add_op(CMD_DIVIDE, 32'h80000000, 1, 2, 3, 0, 0, 0, 0, 32'hffffffff);
    add_op(CMD_NORM, 0, 0, 0, 0, 5, 5, 5, 5, 5);
    add_op(CMD_NORM, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0);
    add_op(CMD_LEN, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0);
    add_op(CMD_EQ, 1, 2, 3, 4, 1, 2, 3, 4, 0);
    add_op(CMD_NE, 1, 2, 3, 4, 1, 2, 3, 4, 0);
    add_op(CMD_REFLECT, 32'h0003_0000, 32'h0002_0000, 0, 32'hffff_0000,
           32'h0001_0000, 0, 0, 0, 0);
    add_op(CMD_LERP, 32'h80000000, 32'h7fffffff, 0, 5, 32'h7fffffff, 32'h80000000, 7, 9,
           32'h0000_8000);
    for (int n = 0; n < N_RANDOM; n++) begin
      op.cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 13)) : 4'($urandom_range(12));
      op.f = rand_word();
      for (int i = 0; i < 4; i++) begin
        op.a[i] = rand_word();
        op.b[i] = rand_word();
      end
      if ((op.cmd == CMD_EQ || op.cmd == CMD_NE) && $urandom_range(1)) begin
        op.b = op.a;
        if ($urandom_range(1)) op.b[$urandom_range(3)] ^= 32'h1 << $urandom_range(31);
      end
      if (op.cmd == CMD_REFLECT && $urandom_range(3) != 0) begin
        for (int i = 0; i < 4; i++) op.b[i] = 0;
        op.b[$urandom_range(3)] = $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
      end
      op_queue.push_back(op);
    end
    n_total = op_queue.size();
    repeat (11) @(posedge clk);
    rst <= 0;
    while (op_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (result_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
